// ----- sv/rtfue_pkg.sv -----
`default_nettype none

package rtfue_pkg;

  // magnitude of an escape fits 16 bits (largest is 32768)
  localparam int MagWidth  = 16;
  localparam int NumDigits = 5;
  localparam int AccWidth  = 21;

  // what one input byte asks the emitter to write
  typedef logic [1:0] job_kind_t;
  localparam job_kind_t KIND_NONE     = 2'd0;
  localparam job_kind_t KIND_CHAR     = 2'd1;
  localparam job_kind_t KIND_BSL_CHAR = 2'd2;
  localparam job_kind_t KIND_ESC      = 2'd3;

  typedef struct packed {
    job_kind_t             kind;
    logic [6:0]            ch;
    logic                  neg;
    logic [MagWidth-1:0]   mag;
    logic                  run_end;
    logic                  text_end;
  } job_t;

  typedef logic [3:0] bcd_digit_t;

  typedef struct packed {
    logic                start;
    logic [MagWidth-1:0] mag;
  } bcd_req_t;

  typedef struct packed {
    logic                            done;
    bcd_digit_t [NumDigits-1:0]      digits;
  } bcd_rsp_t;

  // ascii characters written by the block
  localparam logic [6:0] CH_BSL    = 7'h5C;
  localparam logic [6:0] CH_LBRACE = 7'h7B;
  localparam logic [6:0] CH_RBRACE = 7'h7D;
  localparam logic [6:0] CH_U      = 7'h75;
  localparam logic [6:0] CH_MINUS  = 7'h2D;
  localparam logic [6:0] CH_QMARK  = 7'h3F;
  localparam logic [6:0] CH_ZERO   = 7'h30;

endpackage

`default_nettype wire

// ----- sv/rtfue_in_if.sv -----
`default_nettype none

interface rtfue_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_last;

  modport source (output valid, output in_byte, output text_last, input ready);
  modport sink (input valid, input in_byte, input text_last, output ready);
endinterface

`default_nettype wire

// ----- sv/rtfue_out_if.sv -----
`default_nettype none

interface rtfue_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_byte;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output run_last, output text_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input text_end,
                output ready);
endinterface

`default_nettype wire

// ----- sv/rtfue_dec.sv -----
`default_nettype none

module rtfue_dec (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          text_last,
  output rtfue_pkg::job_t job
);
  import rtfue_pkg::*;

  // 65536 - 0xDC00 and 65536 - (0xD800 - 0x40)
  localparam logic [MagWidth-1:0] LowSurBase  = 16'h2400;
  localparam logic [MagWidth-1:0] HighSurBase = 16'h2840;

  logic [AccWidth-1:0] acc;
  logic [AccWidth-1:0] acc_next;
  logic [1:0]          bytes_left;
  logic [1:0]          bytes_left_next;
  logic [AccWidth-1:0] cont_acc;
  logic [1:0]          left_dec;

  // map a finished code point onto an emitter job
  function automatic job_t code_point_job(input logic [AccWidth-1:0] cp);
    job_t j;
    j         = '0;
    j.run_end = 1'b1;
    j.ch      = cp[6:0];
    if (cp == AccWidth'(CH_BSL) || cp == AccWidth'(CH_LBRACE) ||
        cp == AccWidth'(CH_RBRACE)) begin
      j.kind = KIND_BSL_CHAR;
    end else if (cp[AccWidth-1:7] == '0) begin
      j.kind = KIND_CHAR;
    end else if (cp[AccWidth-1:16] == '0) begin
      j.kind = KIND_ESC;
      j.neg  = cp[15];
      j.mag  = cp[15] ? (16'd0 - cp[15:0]) : cp[15:0];
    end else begin
      // low half of the surrogate pair
      j.kind = KIND_ESC;
      j.neg  = 1'b1;
      j.mag  = LowSurBase - MagWidth'(cp[9:0]);
    end
    return j;
  endfunction

  // decode step for the byte on the input
  always_comb begin
    cont_acc        = {acc[AccWidth-7:0], in_byte[5:0]};
    left_dec        = bytes_left - 2'd1;
    acc_next        = acc;
    bytes_left_next = bytes_left;
    job             = '0;
    if (bytes_left == 2'd0) begin
      if (!in_byte[7]) begin
        job = code_point_job(AccWidth'(in_byte[6:0]));
      end else if (in_byte[7:5] == 3'b110) begin
        acc_next        = AccWidth'(in_byte[4:0]);
        bytes_left_next = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        acc_next        = AccWidth'(in_byte[3:0]);
        bytes_left_next = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        acc_next        = AccWidth'(in_byte[2:0]);
        bytes_left_next = 2'd3;
      end
    end else begin
      acc_next        = cont_acc;
      bytes_left_next = left_dec;
      if (left_dec == 2'd0) begin
        job      = code_point_job(cont_acc);
        acc_next = '0;
      end else if (left_dec == 2'd1 && cont_acc[AccWidth-1:10] != '0 && !text_last) begin
        // high half of the pair, known after the third byte
        job.kind    = KIND_ESC;
        job.neg     = 1'b1;
        job.mag     = HighSurBase - MagWidth'(cont_acc[14:4]);
        job.run_end = 1'b0;
      end
    end
    if (text_last) begin
      acc_next        = '0;
      bytes_left_next = 2'd0;
    end
    job.text_end = text_last;
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      bytes_left <= 2'd0;
    end else if (accept) begin
      acc        <= acc_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rtfue_bcd.sv -----
`default_nettype none

module rtfue_bcd (
  input  logic                clk,
  input  logic                rst,
  input  rtfue_pkg::bcd_req_t req,
  output rtfue_pkg::bcd_rsp_t rsp
);
  import rtfue_pkg::*;

  localparam int CntWidth = $clog2(MagWidth + 1);

  logic [MagWidth-1:0]        bin;
  bcd_digit_t [NumDigits-1:0] digits;
  bcd_digit_t [NumDigits-1:0] adj;
  logic [4*NumDigits:0]       shifted;
  logic [CntWidth-1:0]        cnt;
  logic                       busy;
  logic                       done;

  // add-3 correction on every digit, then shift one binary bit in
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
    shifted = {adj, bin[MagWidth-1]};
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CntWidth'(MagWidth);
    end else if (busy) begin
      cnt <= cnt - CntWidth'(1);
      if (cnt == CntWidth'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      bin    <= req.mag;
      digits <= '0;
    end else if (busy) begin
      bin    <= {bin[MagWidth-2:0], 1'b0};
      digits <= shifted[4*NumDigits-1:0];
    end
  end

  assign rsp.done   = done;
  assign rsp.digits = digits;

endmodule

`default_nettype wire

// ----- sv/rtfue_emit.sv -----
`default_nettype none

module rtfue_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rtfue_pkg::job_t     job,
  output logic                idle,
  output rtfue_pkg::bcd_req_t bcd_req,
  input  rtfue_pkg::bcd_rsp_t bcd_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          out_byte,
  output logic                run_last,
  output logic                text_end
);
  import rtfue_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PRE   = 4'd1;
  localparam logic [3:0] ST_CHAR  = 4'd2;
  localparam logic [3:0] ST_BS    = 4'd3;
  localparam logic [3:0] ST_U     = 4'd4;
  localparam logic [3:0] ST_MINUS = 4'd5;
  localparam logic [3:0] ST_WAIT  = 4'd6;
  localparam logic [3:0] ST_DIGIT = 4'd7;
  localparam logic [3:0] ST_QMARK = 4'd8;

  localparam int IdxWidth = $clog2(NumDigits);

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [IdxWidth-1:0] idx;
  logic [IdxWidth-1:0] idx_next;
  logic [IdxWidth-1:0] first_idx;
  job_t                job_q;
  logic                can_load;
  logic                emit;
  logic [6:0]          byte_v;
  logic                run_v;
  logic                end_v;

  assign idle     = (state == ST_IDLE);
  assign can_load = !out_valid || out_ready;

  assign bcd_req.start = idle && start && (job.kind == KIND_ESC);
  assign bcd_req.mag   = job.mag;

  // most significant nonzero digit, units digit when the value is zero
  always_comb begin
    first_idx = '0;
    for (int i = 1; i < NumDigits; i++) begin
      if (bcd_rsp.digits[i] != 4'd0) begin
        first_idx = IdxWidth'(i);
      end
    end
  end

  // sequencer: every state but ST_IDLE and ST_WAIT writes output bytes, ST_DIGIT one per digit
  always_comb begin
    state_next = state;
    idx_next   = idx;
    emit       = 1'b0;
    byte_v     = CH_BSL;
    run_v      = 1'b0;
    end_v      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (job.kind)
            KIND_NONE:     state_next = ST_IDLE;
            KIND_CHAR:     state_next = ST_CHAR;
            KIND_BSL_CHAR: state_next = ST_PRE;
            KIND_ESC:      state_next = ST_BS;
          endcase
        end
      end
      ST_PRE: begin
        emit = 1'b1;
        if (can_load) state_next = ST_CHAR;
      end
      ST_CHAR: begin
        emit   = 1'b1;
        byte_v = job_q.ch;
        run_v  = 1'b1;
        end_v  = job_q.text_end;
        if (can_load) state_next = ST_IDLE;
      end
      ST_BS: begin
        emit = 1'b1;
        if (can_load) state_next = ST_U;
      end
      ST_U: begin
        emit   = 1'b1;
        byte_v = CH_U;
        if (can_load) state_next = job_q.neg ? ST_MINUS : ST_WAIT;
      end
      ST_MINUS: begin
        emit   = 1'b1;
        byte_v = CH_MINUS;
        if (can_load) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (bcd_rsp.done) begin
          idx_next   = first_idx;
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        emit   = 1'b1;
        byte_v = CH_ZERO | {3'b000, bcd_rsp.digits[idx]};
        if (can_load) begin
          if (idx == '0) begin
            state_next = ST_QMARK;
          end else begin
            idx_next = idx - IdxWidth'(1);
          end
        end
      end
      ST_QMARK: begin
        emit   = 1'b1;
        byte_v = CH_QMARK;
        run_v  = job_q.run_end;
        end_v  = job_q.text_end;
        if (can_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit && can_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // job and output payload
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (idle && start) begin
      job_q <= job;
    end
    if (emit && can_load) begin
      out_byte <= byte_v;
      run_last <= run_v;
      text_end <= end_v;
    end
  end

endmodule

`default_nettype wire

// ----- sv/utf8_to_rtf_unicode_escape_unit.sv -----
`default_nettype none

// UTF-8 to RTF unicode-escape converter. Takes one UTF-8 byte per input
// transaction and writes the escaped ASCII text one byte per output
// transaction, with run_last on the last byte of each code point and
// text_end on the last byte caused by a byte marked text_last. A byte that
// writes nothing (lead, continuation, skipped byte) leaves the unit idle. A
// plain character is written as itself, after a leading backslash when it
// needs one. An escape \uN? waits after its prefix for the 16-step
// binary-to-decimal shift unit, which runs once per escape, then writes its
// digits and the closing byte. Input is not ready while a run is being
// written; the output register lets the next byte be taken while the last
// byte of a run waits.
module utf8_to_rtf_unicode_escape_unit (
  input  logic      clk,
  input  logic      rst,
  rtfue_in_if.sink  in_chan,
  rtfue_out_if.source out_chan
);
  import rtfue_pkg::*;

  logic       accept;
  logic       idle;
  job_t       job;
  bcd_req_t   bcd_req;
  bcd_rsp_t   bcd_rsp;
  logic       out_valid;
  logic [6:0] out_byte;
  logic       run_last;
  logic       text_end;

  // input transaction
  assign in_chan.ready = idle;
  assign accept        = in_chan.valid && idle;

  rtfue_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_chan.in_byte),
    .text_last (in_chan.text_last),
    .job       (job)
  );

  rtfue_bcd u_bcd (
    .clk (clk),
    .rst (rst),
    .req (bcd_req),
    .rsp (bcd_rsp)
  );

  rtfue_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .job       (job),
    .idle      (idle),
    .bcd_req   (bcd_req),
    .bcd_rsp   (bcd_rsp),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_end  (text_end)
  );

  // output transaction
  assign out_chan.valid    = out_valid;
  assign out_chan.out_byte = out_byte;
  assign out_chan.run_last = run_last;
  assign out_chan.text_end = text_end;

endmodule

`default_nettype wire

// ----- sv/rtfue_check.sv -----
`default_nettype none

module rtfue_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_byte,
  input logic       run_last,
  input logic       text_end
);

  // a pending output transaction stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  // a pending output transaction keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(run_last) && $stable(text_end))
    else $error("output payload changed while stalled");

  // the last byte of a text always closes a code point
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_end |-> run_last)
    else $error("text_end without run_last");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a refused input transaction stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input valid dropped while refused");

endmodule

bind utf8_to_rtf_unicode_escape_unit rtfue_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .run_last  (out_chan.run_last),
  .text_end  (out_chan.text_end)
);

`default_nettype wire
